[rtl/rab_pkg.sv]
// Types, constants and helper functions shared by the ray versus box slab test.
`timescale 1ns / 1ps
package rab_pkg;

    // Q16.16 limits and format
    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 49;        // |(bound - origin) << 16| fits 49 bits
    localparam int DIV_STEPS = NUM_W;     // one quotient bit per divider stage
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Input item: ray and box
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_in_item;

    // Output item: hit flag, times and points
    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_near;
        logic signed [31:0] t_far;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] entry_z;
        logic signed [31:0] exit_x;
        logic signed [31:0] exit_y;
        logic signed [31:0] exit_z;
    } t_out_item;

    // Side data that travels beside the divider stages
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0][31:0] absd;
        logic [5:0]       neg;
        logic [2:0]       dz;
        logic             empty;
    } t_side;

    // Classified item handed from front to back: t[2a] from min, t[2a+1] from max
    typedef struct packed {
        logic [5:0][31:0] t;
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0]       dz;
        logic             empty;
    } t_slab;

    // Apply sign to a quotient magnitude and saturate to 32 bits
    function automatic logic [31:0] sat_quot(input logic [NUM_W-1:0] q, input logic neg);
        logic [31:0] res;
        begin
            if (!neg) begin
                res = (q[NUM_W-1:31] != '0) ? Q_MAX : q[31:0];
            end else begin
                if ((q[NUM_W-1:32] != '0) || (q[31] && (q[30:0] != '0))) begin
                    res = Q_MIN;
                end else begin
                    res = 32'(-q[31:0]);
                end
            end
            return res;
        end
    endfunction

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] res;
        begin
            if (v > 64'sh0000_0000_7FFF_FFFF) begin
                res = Q_MAX;
            end else if (v < -64'sh0000_0000_8000_0000) begin
                res = Q_MIN;
            end else begin
                res = v[31:0];
            end
            return res;
        end
    endfunction

endpackage

[rtl/rab_front.sv]
// Front part: takes items, classifies zero-direction axes and runs six pipelined dividers.
`timescale 1ns / 1ps
module rab_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rab_pkg::t_in_item i_in_item,
    input  logic             i_q_full,
    output logic             o_push,
    output rab_pkg::t_slab   o_slab
);
    import rab_pkg::*;

    logic                   fadv;
    logic                   r_vld  [0:DIV_STEPS];
    logic [5:0][NUM_W-1:0]  r_nq   [0:DIV_STEPS];
    logic [5:0][31:0]       r_rem  [0:DIV_STEPS];
    t_side                  r_side [0:DIV_STEPS];

    logic [5:0][NUM_W-1:0]  n_nq0;
    t_side                  n_side0;

    // Advance unless the last stage holds an item the queue cannot take
    assign fadv       = !(r_vld[DIV_STEPS] && i_q_full);
    assign o_in_stall = !fadv;
    assign o_push     = r_vld[DIV_STEPS] && !i_q_full;

    // Form numerator magnitudes, signs and zero-direction classification
    always_comb begin
        logic signed [31:0] org  [0:2];
        logic signed [31:0] dir  [0:2];
        logic signed [31:0] bmin [0:2];
        logic signed [31:0] bmax [0:2];
        logic signed [32:0] diff;
        logic signed [NUM_W-1:0] num;
        org[0]  = i_in_item.origin_x;  org[1]  = i_in_item.origin_y;
        org[2]  = i_in_item.origin_z;
        dir[0]  = i_in_item.dir_x;     dir[1]  = i_in_item.dir_y;
        dir[2]  = i_in_item.dir_z;
        bmin[0] = i_in_item.box_min_x; bmin[1] = i_in_item.box_min_y;
        bmin[2] = i_in_item.box_min_z;
        bmax[0] = i_in_item.box_max_x; bmax[1] = i_in_item.box_max_y;
        bmax[2] = i_in_item.box_max_z;
        n_side0 = '0;
        n_nq0   = '0;
        for (int a = 0; a < 3; a++) begin
            n_side0.org[a]  = org[a];
            n_side0.dir[a]  = dir[a];
            n_side0.absd[a] = dir[a][31] ? 32'(-dir[a]) : dir[a];
            n_side0.dz[a]   = (dir[a] == 32'sd0);
            if (n_side0.dz[a] && ((org[a] < bmin[a]) || (org[a] > bmax[a]))) begin
                n_side0.empty = 1'b1;
            end
            // Slab time numerator from the min bound
            diff = 33'(bmin[a]) - 33'(org[a]);
            num  = {diff, {FRAC_BITS{1'b0}}};
            n_nq0[2*a]        = num[NUM_W-1] ? NUM_W'(-num) : num;
            n_side0.neg[2*a]  = num[NUM_W-1] ^ dir[a][31];
            // Slab time numerator from the max bound
            diff = 33'(bmax[a]) - 33'(org[a]);
            num  = {diff, {FRAC_BITS{1'b0}}};
            n_nq0[2*a+1]       = num[NUM_W-1] ? NUM_W'(-num) : num;
            n_side0.neg[2*a+1] = num[NUM_W-1] ^ dir[a][31];
        end
    end

    // Load the first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (fadv) begin
            r_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fadv) begin
            r_nq[0]   <= n_nq0;
            r_rem[0]  <= '0;
            r_side[0] <= n_side0;
        end
    end

    // Restoring divider stages, one quotient bit each
    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        logic [5:0][NUM_W-1:0] n_nq;
        logic [5:0][31:0]      n_rem;

        always_comb begin
            logic [32:0] trial;
            logic [32:0] dvs;
            logic        ge;
            for (int j = 0; j < 6; j++) begin
                dvs      = {1'b0, r_side[s-1].absd[j >> 1]};
                trial    = {r_rem[s-1][j], r_nq[s-1][j][NUM_W-1]};
                ge       = (trial >= dvs);
                n_rem[j] = ge ? 32'(trial - dvs) : trial[31:0];
                n_nq[j]  = {r_nq[s-1][j][NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (fadv) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (fadv) begin
                r_nq[s]   <= n_nq;
                r_rem[s]  <= n_rem;
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Sign and saturate the quotients for the queue
    always_comb begin
        o_slab       = '0;
        o_slab.org   = r_side[DIV_STEPS].org;
        o_slab.dir   = r_side[DIV_STEPS].dir;
        o_slab.dz    = r_side[DIV_STEPS].dz;
        o_slab.empty = r_side[DIV_STEPS].empty;
        for (int j = 0; j < 6; j++) begin
            o_slab.t[j] = sat_quot(r_nq[DIV_STEPS][j], r_side[DIV_STEPS].neg[j]);
        end
    end

endmodule

[rtl/rab_queue.sv]
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
module rab_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rab_pkg::t_slab i_slab,
    input  logic           i_pop,
    output rab_pkg::t_slab o_slab,
    output logic           o_full,
    output logic           o_nonempty
);
    import rab_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_slab              r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_slab     = r_mem[r_rd_ptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_slab;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/rab_back.sv]
// Back part: combines slab times, forms entry and exit points and holds the output item.
`timescale 1ns / 1ps
module rab_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  rab_pkg::t_slab    i_slab,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rab_pkg::t_out_item o_out_item
);
    import rab_pkg::*;

    logic               ben;
    logic               n_a_hit;
    logic signed [31:0] n_a_tn;
    logic signed [31:0] n_a_tf;

    logic               r_a_vld;
    logic               r_a_hit;
    logic signed [31:0] r_a_tn;
    logic signed [31:0] r_a_tf;
    logic [2:0][31:0]   r_a_org;
    logic [2:0][31:0]   r_a_dir;

    logic               r_b_vld;
    logic               r_b_hit;
    logic signed [31:0] r_b_tn;
    logic signed [31:0] r_b_tf;
    logic [2:0][31:0]   r_b_org;
    logic signed [63:0] r_b_prod [0:5];

    logic [5:0][31:0]   n_pt;
    logic               r_out_valid;
    t_out_item          r_out_item;

    // Move the whole back pipeline unless the output item is held
    assign ben         = !(r_out_valid && i_out_stall);
    assign o_pop       = ben && i_nonempty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Reduce slab times to near and far times and the hit flag
    always_comb begin
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] floor0;
        n_a_tn = Q_MIN;
        n_a_tf = Q_MAX;
        for (int a = 0; a < 3; a++) begin
            t1 = $signed(i_slab.t[2*a]);
            t2 = $signed(i_slab.t[2*a+1]);
            lo = (t1 < t2) ? t1 : t2;
            hi = (t1 < t2) ? t2 : t1;
            if (!i_slab.dz[a]) begin
                if (lo > n_a_tn) n_a_tn = lo;
                if (hi < n_a_tf) n_a_tf = hi;
            end
        end
        if (i_slab.empty) begin
            n_a_tn = Q_MAX;
            n_a_tf = Q_MIN;
        end
        floor0  = (n_a_tn > 32'sd0) ? n_a_tn : 32'sd0;
        n_a_hit = (n_a_tf >= floor0);
    end

    // Truncate products toward zero, add origin, saturate
    always_comb begin
        logic signed [63:0] adj;
        logic signed [63:0] sum;
        for (int j = 0; j < 6; j++) begin
            adj     = r_b_prod[j] + (r_b_prod[j][63] ? 64'sd65535 : 64'sd0);
            sum     = (adj >>> FRAC_BITS) + 64'($signed(r_b_org[j % 3]));
            n_pt[j] = sat64(sum);
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (ben) begin
            r_a_vld     <= i_nonempty;
            r_b_vld     <= r_a_vld;
            r_out_valid <= r_b_vld;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_a_tn  <= n_a_tn;
            r_a_tf  <= n_a_tf;
            r_a_hit <= n_a_hit;
            r_a_org <= i_slab.org;
            r_a_dir <= i_slab.dir;

            r_b_tn  <= r_a_tn;
            r_b_tf  <= r_a_tf;
            r_b_hit <= r_a_hit;
            r_b_org <= r_a_org;
            for (int a = 0; a < 3; a++) begin
                r_b_prod[a]   <= r_a_tn * $signed(r_a_dir[a]);
                r_b_prod[a+3] <= r_a_tf * $signed(r_a_dir[a]);
            end

            r_out_item.hit     <= r_b_hit;
            r_out_item.t_near  <= r_b_tn;
            r_out_item.t_far   <= r_b_tf;
            r_out_item.entry_x <= n_pt[0];
            r_out_item.entry_y <= n_pt[1];
            r_out_item.entry_z <= n_pt[2];
            r_out_item.exit_x  <= n_pt[3];
            r_out_item.exit_y  <= n_pt[4];
            r_out_item.exit_z  <= n_pt[5];
        end
    end

endmodule

[rtl/ray_aabb_slab_intersection.sv]
// Top level of the 3D ray versus axis-aligned box slab test.
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_item carries one ray (origin,
//   direction) and one box (min, max corners), all signed Q16.16. An item is
//   taken at a clock edge with valid high and stall low.
//   Output channel o_out_valid / i_out_stall / o_out_item carries the hit flag,
//   near and far times and the entry and exit points, saturated to Q16.16.
//   Throughput: one item per cycle while nothing stalls. From acceptance to
//   o_out_valid an item passes the input register, the 49-stage restoring
//   divider (one quotient bit per stage), then a queue slot, the time
//   reduction, the multiply stage and the output register.
//   The front pipeline and the back pipeline stall independently; the queue
//   between them holds QUEUE_DEPTH items. While the receiver stalls, the output
//   item holds, the front fills the queue, and o_in_stall rises only once the
//   queue is full and the front's last stage holds an item.
//   Reset (i_rst_n low at a clock edge) empties every stage and the queue;
//   no item is lost or repeated outside reset.
`timescale 1ns / 1ps
module ray_aabb_slab_intersection #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rab_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rab_pkg::t_out_item o_out_item
);
    import rab_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_nonempty;
    t_slab front_slab;
    t_slab back_slab;

    // Accept and divide
    rab_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_slab     (front_slab)
    );

    // Decouple front and back
    rab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_slab     (front_slab),
        .i_pop      (pop),
        .o_slab     (back_slab),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    // Reduce and form points
    rab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_slab      (back_slab),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/rab_chk.sv]
// Port-level checks for the slab test block, bound to the top level.
`timescale 1ns / 1ps
module rab_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input rab_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rab_pkg::t_out_item o_out_item
);
    import rab_pkg::*;

    // Held output item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // Hit flag agrees with the reported times
    a_hit_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.hit ==
            ((o_out_item.t_far >= 32'sd0) && (o_out_item.t_far >= o_out_item.t_near))))
        else $error("hit flag does not match times");

    // Reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Reset leaves the front ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind ray_aabb_slab_intersection rab_chk u_chk (.*);

[tb/testbench.sv]
// Self-checking testbench for the 3D ray versus axis-aligned box slab test.
`timescale 1ns / 1ps
module testbench;
    import rab_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 9;
    localparam int NUM_RANDOM = 1300;
    localparam int DRAIN_WAIT = 80;
    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_REPORT = 10;
    localparam longint ONE_Q  = 65536;

    // Clamp a wide value to the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Compute hit flag, slab times and entry/exit points for one ray and box
    function automatic t_out_item slab_hit(input t_in_item it);
        longint org[3], dir[3], bmin[3], bmax[3];
        longint tn, tf, t1, t2, lo, hi, floor0, pt;
        bit empty;
        t_out_item r;
        org  = '{longint'(it.origin_x), longint'(it.origin_y), longint'(it.origin_z)};
        dir  = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
        bmin = '{longint'(it.box_min_x), longint'(it.box_min_y), longint'(it.box_min_z)};
        bmax = '{longint'(it.box_max_x), longint'(it.box_max_y), longint'(it.box_max_z)};
        tn = -64'sd2147483648;
        tf = 64'sd2147483647;
        empty = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (dir[a] == 0) begin
                if (org[a] < bmin[a] || org[a] > bmax[a]) empty = 1'b1;
            end else begin
                t1 = clamp32(((bmin[a] - org[a]) * ONE_Q) / dir[a]);
                t2 = clamp32(((bmax[a] - org[a]) * ONE_Q) / dir[a]);
                lo = (t1 < t2) ? t1 : t2;
                hi = (t1 < t2) ? t2 : t1;
                if (lo > tn) tn = lo;
                if (hi < tf) tf = hi;
            end
        end
        if (empty) begin
            tn = 64'sd2147483647;
            tf = -64'sd2147483648;
        end
        floor0 = (tn > 0) ? tn : 0;
        r.hit    = (tf >= floor0);
        r.t_near = tn[31:0];
        r.t_far  = tf[31:0];
        pt = clamp32(org[0] + (tn * dir[0]) / ONE_Q); r.entry_x = pt[31:0];
        pt = clamp32(org[1] + (tn * dir[1]) / ONE_Q); r.entry_y = pt[31:0];
        pt = clamp32(org[2] + (tn * dir[2]) / ONE_Q); r.entry_z = pt[31:0];
        pt = clamp32(org[0] + (tf * dir[0]) / ONE_Q); r.exit_x  = pt[31:0];
        pt = clamp32(org[1] + (tf * dir[1]) / ONE_Q); r.exit_y  = pt[31:0];
        pt = clamp32(org[2] + (tf * dir[2]) / ONE_Q); r.exit_z  = pt[31:0];
        return r;
    endfunction

    // Hold expected results in order and compare each delivered item
    class hit_scoreboard;
        t_out_item expected_hits[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_ray(input t_in_item it);
            expected_hits.push_back(slab_hit(it));
        endfunction

        function void check_hit(input t_out_item got);
            t_out_item exp_item;
            logic [31:0] ev[9], gv[9];
            string names[9];
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result item %h", got);
                return;
            end
            exp_item = expected_hits.pop_front();
            names = '{"hit", "t_near", "t_far", "entry_x", "entry_y", "entry_z",
                      "exit_x", "exit_y", "exit_z"};
            ev = '{32'(exp_item.hit), exp_item.t_near, exp_item.t_far, exp_item.entry_x,
                   exp_item.entry_y, exp_item.entry_z, exp_item.exit_x, exp_item.exit_y,
                   exp_item.exit_z};
            gv = '{32'(got.hit), got.t_near, got.t_far, got.entry_x, got.entry_y,
                   got.entry_z, got.exit_x, got.exit_y, got.exit_z};
            for (int f = 0; f < 9; f++) begin
                if (ev[f] !== gv[f]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("%s mismatch: expected %h, got %h", names[f], ev[f], gv[f]);
                end
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    hit_scoreboard sb = new();
    int idle_cycles = 0;

    ray_aabb_slab_intersection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Check each delivered result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_hit(o_out_item);
    end

    // Stall the output on a pattern of changing density
    int stall_mode = 0;
    int mode_left  = 100;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(40, 250);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2: i_out_stall <= ($urandom_range(0, 99) < 85);
            default: i_out_stall <= ($urandom_range(0, 15) == 0) ? ~i_out_stall : i_out_stall;
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    int burst_left = 0;

    // Present one item and hold it until accepted; often idle between bursts
    task automatic send_ray(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_ray(it);
    endtask

    function automatic logic [31:0] small_q();
        return 32'($signed($urandom_range(0, 800)) - 400) <<< 16
               | 32'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] edge_val();
        case ($urandom_range(0, 6))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'd0;
            3: return 32'd1;
            4: return 32'hFFFF_FFFF;
            5: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // Aimed ray: box with random extent, origin nearby, direction mostly toward the box
    function automatic t_in_item aimed_ray();
        t_in_item it;
        logic [31:0] lo[3], hi[3], org[3], dir[3];
        for (int a = 0; a < 3; a++) begin
            lo[a]  = small_q();
            hi[a]  = lo[a] + ($urandom_range(0, 100) << 16) + $urandom_range(0, 65535);
            org[a] = small_q();
            dir[a] = ((lo[a] + hi[a]) >>> 1) - org[a];
            dir[a] = $signed(dir[a]) >>> $urandom_range(0, 8);
            dir[a] = dir[a] + 32'($signed($urandom_range(0, 2000)) - 1000);
            if ($urandom_range(0, 9) == 0) dir[a] = 32'd0;
            if ($urandom_range(0, 19) == 0) dir[a] = -dir[a];
        end
        if ($urandom_range(0, 15) == 0) begin
            it.box_min_x = hi[0]; it.box_max_x = lo[0];
        end else begin
            it.box_min_x = lo[0]; it.box_max_x = hi[0];
        end
        it.box_min_y = lo[1]; it.box_max_y = hi[1];
        it.box_min_z = lo[2]; it.box_max_z = hi[2];
        it.origin_x = org[0]; it.origin_y = org[1]; it.origin_z = org[2];
        it.dir_x = dir[0]; it.dir_y = dir[1]; it.dir_z = dir[2];
        return it;
    endfunction

    function automatic t_in_item mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                        input logic [31:0] nx, ny, nz, xx, xy, xz);
        t_in_item it;
        it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
        it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
        it.box_min_x = nx; it.box_min_y = ny; it.box_min_z = nz;
        it.box_max_x = xx; it.box_max_y = xy; it.box_max_z = xz;
        return it;
    endfunction

    initial begin
        t_in_item it;
        int pick;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain hit, miss, zero directions, inverted box, extremes
        send_ray(mk_ray(32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0,
                        32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_ray(mk_ray(32'hFFFB_0000, 32'h0005_0000, 0, 32'h0001_0000, 0, 0,
                        32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000,
                        32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(mk_ray(0, 0, 0, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        send_ray(mk_ray(0, 0, 0, 0, 32'h0001_0000, 0,
                        32'h0001_0000, 0, 0, 32'hFFFF_0000, 32'h0004_0000, 0));
        send_ray(mk_ray(Q_MIN, Q_MIN, Q_MIN, 1, 1, 1, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX));
        send_ray(mk_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
                        Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_ray(mk_ray(Q_MAX, Q_MIN, 0, Q_MAX, Q_MAX, Q_MAX,
                        Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_ray(mk_ray(Q_MIN, Q_MAX, 0, 32'hFFFF_FFFF, 1, Q_MIN,
                        Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_ray(mk_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                        32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
        send_ray(mk_ray(32'h0010_0000, 0, 0, 32'h0001_0000, 0, 0,
                        0, 0, 0, 32'h0001_0000, 0, 0));
        send_ray(mk_ray(Q_MIN, 0, 0, 0, 0, 0, Q_MIN, 0, 0, Q_MIN, 0, 0));
        send_ray(mk_ray(Q_MAX, 0, 0, 0, 0, 0, Q_MAX, 0, 0, Q_MIN, 0, 0));
        send_ray(mk_ray(0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_0000,
                        32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000,
                        32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
        for (int k = 0; k < 6; k++) begin
            it = mk_ray(edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
                        edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
                        edge_val(), edge_val());
            send_ray(it);
        end

        // Random: mostly aimed rays, some raw fields and extreme values
        for (int n = 0; n < NUM_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                it = aimed_ray();
            end else if (pick < 85) begin
                it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom});
            end else begin
                it = mk_ray(edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
                            edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
                            edge_val(), edge_val());
            end
            send_ray(it);
        end
        i_in_valid <= 1'b0;

        // Drain and let any stray item show up
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
